@@ src/gpdp_pkg.sv @@
// ----------------------------------------------------------------------------
// gpdp_pkg
// Shared types and constants for the glyph pixel depth packer.
// ----------------------------------------------------------------------------
package gpdp_pkg;

  // output format codes
  localparam logic [2:0] MODE_TWO_BIT  = 3'd0;
  localparam logic [2:0] MODE_FOUR_BIT = 3'd1;
  localparam logic [2:0] MODE_GRAY8    = 3'd2;
  localparam logic [2:0] MODE_MONO8    = 3'd3;
  localparam logic [2:0] MODE_ONE_BIT  = 3'd4;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MODE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOLD_ENABLE = 1'd1;

  // reset values of the configuration registers
  localparam logic [2:0] OUT_MODE_RESET = MODE_GRAY8;

  // two-bit quantiser thresholds and gray bold threshold
  localparam logic [7:0] THRESH_HIGH = 8'd200;
  localparam logic [7:0] THRESH_MID  = 8'd150;
  localparam logic [7:0] THRESH_LOW  = 8'd100;
  localparam logic [7:0] BOLD_FLOOR  = 8'd31;
  localparam logic [7:0] FULL_BYTE   = 8'd255;

  // reciprocal of 17 in 12 fractional bits, exact for all 8-bit inputs
  localparam logic [15:0] RECIP_17 = 16'd241;

  // work for the back end: one or two bytes caused by one pixel
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       glyph;
  } entry_t;

  // gray to two-bit code
  function automatic logic [1:0] quantise_two(input logic [7:0] v);
    logic [1:0] q;
    if (v > THRESH_HIGH) q = 2'd3;
    else if (v > THRESH_MID) q = 2'd2;
    else if (v > THRESH_LOW) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  // gray to four-bit code, floor(v * 15 / 255) = floor(v / 17)
  function automatic logic [3:0] quantise_four(input logic [7:0] v);
    logic [15:0] prod;
    prod = {8'd0, v} * RECIP_17;
    return prod[15:12];
  endfunction

endpackage

@@ src/gpdp_front.sv @@
// ----------------------------------------------------------------------------
// gpdp_front
// Accepts pixels, keeps the running packing and bold state and classifies
// each pixel into the bytes it causes.
// ----------------------------------------------------------------------------
module gpdp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gpdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gpdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [7:0]                       pixel_value,
  input  logic                             row_end,
  input  logic                             glyph_end,
  output logic                             entry_valid,
  output gpdp_pkg::entry_t                 entry
);

  logic [2:0] out_mode;
  logic       bold_enable;
  logic [7:0] pack_acc;
  logic [2:0] pack_cnt;
  logic [7:0] bold_carry;

  // mode decode
  logic       packed_mode;
  logic [2:0] nbits;
  logic [3:0] code;

  always_comb begin
    packed_mode = 1'b1;
    nbits       = 3'd0;
    code        = 4'd0;
    unique case (out_mode)
      gpdp_pkg::MODE_TWO_BIT: begin
        nbits = 3'd2;
        code  = {2'd0, gpdp_pkg::quantise_two(pixel_value)};
      end
      gpdp_pkg::MODE_FOUR_BIT: begin
        nbits = 3'd4;
        code  = gpdp_pkg::quantise_four(pixel_value);
      end
      gpdp_pkg::MODE_ONE_BIT: begin
        nbits = 3'd1;
        code  = {3'd0, |pixel_value};
      end
      default: begin
        packed_mode = 1'b0;
      end
    endcase
  end

  // packed path: append code, complete a byte or flush at glyph end
  logic [3:0]  total;
  logic [11:0] shifted;
  logic [1:0]  shift_amt;
  logic        byte_done;
  logic [7:0]  done_byte;
  logic [7:0]  pk_acc_upd;
  logic [2:0]  pk_cnt_upd;
  logic        flush;
  logic [7:0]  flush_byte;

  always_comb begin
    total      = {1'b0, pack_cnt} + {1'b0, nbits};
    shifted    = ({4'd0, pack_acc} << nbits) | {8'd0, code};
    shift_amt  = 2'(total - 4'd8);
    byte_done  = (total >= 4'd8);
    done_byte  = 8'(shifted >> shift_amt);
    pk_acc_upd = byte_done ? 8'd0 : shifted[7:0];
    pk_cnt_upd = byte_done ? 3'd0 : total[2:0];
    flush      = glyph_end && (pk_cnt_upd != 3'd0);
    flush_byte = 8'(pk_acc_upd << (4'd8 - {1'b0, pk_cnt_upd}));
  end

  // byte path: gray8 and mono8 with optional right smear
  logic [7:0] carry_in;
  logic [7:0] carry_mid;
  logic [7:0] wide_byte;
  logic       at_row_end;

  always_comb begin
    carry_in   = bold_enable ? bold_carry : 8'd0;
    at_row_end = row_end || glyph_end;
    if (out_mode == gpdp_pkg::MODE_MONO8) begin
      wide_byte = (|pixel_value || |carry_in) ? gpdp_pkg::FULL_BYTE : 8'd0;
      carry_mid = |pixel_value ? gpdp_pkg::FULL_BYTE : 8'd0;
    end else if (pixel_value > gpdp_pkg::BOLD_FLOOR) begin
      wide_byte = (carry_in > pixel_value) ? carry_in : pixel_value;
      carry_mid = pixel_value;
    end else begin
      wide_byte = pixel_value;
      carry_mid = 8'd0;
    end
    if (!bold_enable) begin
      carry_mid = 8'd0;
    end
  end

  // entry for the back end
  always_comb begin
    entry.glyph = glyph_end;
    if (packed_mode) begin
      entry.byte0 = byte_done ? done_byte : flush_byte;
      entry.byte1 = 8'd0;
      entry.two   = 1'b0;
      entry_valid = accept && (byte_done || flush);
    end else begin
      entry.byte0 = wide_byte;
      entry.byte1 = carry_mid;
      entry.two   = at_row_end && bold_enable;
      entry_valid = accept;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_mode    <= gpdp_pkg::OUT_MODE_RESET;
      bold_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gpdp_pkg::REG_OUT_MODE:    out_mode    <= cfg_data;
        gpdp_pkg::REG_BOLD_ENABLE: bold_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // running state, cleared at glyph end
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_acc   <= 8'd0;
      pack_cnt   <= 3'd0;
      bold_carry <= 8'd0;
    end else if (accept) begin
      if (glyph_end) begin
        pack_acc   <= 8'd0;
        pack_cnt   <= 3'd0;
        bold_carry <= 8'd0;
      end else if (packed_mode) begin
        pack_acc <= pk_acc_upd;
        pack_cnt <= pk_cnt_upd;
      end else begin
        bold_carry <= at_row_end ? 8'd0 : carry_mid;
      end
    end
  end

endmodule

@@ src/gpdp_fifo.sv @@
// ----------------------------------------------------------------------------
// gpdp_fifo
// Short entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module gpdp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  gpdp_pkg::entry_t wr_data,
  input  logic             rd_en,
  output gpdp_pkg::entry_t rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gpdp_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/gpdp_back.sv @@
// ----------------------------------------------------------------------------
// gpdp_back
// Splits queued entries into single result bytes and marks the last ones.
// ----------------------------------------------------------------------------
module gpdp_back (
  input  logic             clk,
  input  logic             rst,
  input  gpdp_pkg::entry_t head,
  input  logic             head_empty,
  output logic             head_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             glyph_last
);

  // high when the first byte of a two-byte entry has gone
  logic second;

  logic transfer;

  assign empty      = head_empty;
  assign transfer   = pop && !head_empty;
  assign out_byte   = second ? head.byte1 : head.byte0;
  assign run_last   = second || !head.two;
  assign glyph_last = run_last && head.glyph;
  assign head_pop   = transfer && run_last;

  // byte select within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (transfer) begin
      second <= !run_last;
    end
  end

endmodule

@@ src/glyph_pixel_depth_packer.sv @@
// ----------------------------------------------------------------------------
// glyph_pixel_depth_packer
// Converts a stream of glyph pixels to a packed or byte-wide glyph buffer.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while full is low; its bytes are worked out in
// the same cycle and held in an entry queue of FIFO_DEPTH entries, so pixel
// input and byte output stall independently. Bytes leave one per cycle while
// pop is high and the queue is not empty; the single output byte port sets the
// sustained rate. A pixel gives one byte, two at a bold row end, at most one in
// packed modes, via the queue. Configuration is written through cfg_write/
// cfg_index/cfg_data by the user only while the block is idle; not enforced.
module glyph_pixel_depth_packer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gpdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gpdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       pixel_value,
  input  logic                             row_end,
  input  logic                             glyph_end,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             run_last,
  output logic                             glyph_last
);

  logic             accept;
  logic             entry_valid;
  gpdp_pkg::entry_t entry;
  gpdp_pkg::entry_t head;
  logic             head_empty;
  logic             head_pop;

  assign accept = push && !full;

  // front: pixel classification and running state
  gpdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel_value (pixel_value),
    .row_end     (row_end),
    .glyph_end   (glyph_end),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  // entry queue
  gpdp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (entry_valid),
    .wr_data (entry),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  // back: byte output
  gpdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .glyph_last (glyph_last)
  );

endmodule

@@ src/gpdp_checker.sv @@
// ----------------------------------------------------------------------------
// gpdp_checker
// Port-level checks on the glyph pixel depth packer.
// ----------------------------------------------------------------------------
module gpdp_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic run_last,
  input logic glyph_last
);

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");

  // nothing appears without a pixel transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("result appeared without a pixel transfer");

  // the glyph's final byte is always the last byte of its pixel
  a_glyph_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && glyph_last) |-> run_last)
    else $error("glyph_last without run_last");

  // the second byte of a pixel follows straight after the first
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !run_last) |=> !empty)
    else $error("second byte of a pixel missing");

  // a full queue cannot be empty
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full and empty together");

endmodule

bind glyph_pixel_depth_packer gpdp_checker u_gpdp_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .run_last   (run_last),
  .glyph_last (glyph_last)
);

@@ dv/gpdp_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpdp_tb_pkg
// Byte tracker for the glyph packer bench: keeps its own copy of the packing
// and bold state, works out the bytes each pixel transfer should give and
// checks the bytes that leave the block against them in order.
// ----------------------------------------------------------------------------
package gpdp_tb_pkg;

  // one expected byte with its markers
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       glyph_last;
  } glyph_byte_t;

  class packer_byte_tracker;

    logic [2:0]  out_mode;
    logic        bold_on;
    logic [7:0]  pend_bits;
    logic [2:0]  pend_count;
    logic [7:0]  smear;
    glyph_byte_t expected_bytes[$];
    int          errors;

    function new();
      out_mode   = gpdp_pkg::OUT_MODE_RESET;
      bold_on    = 1'b0;
      pend_bits  = '0;
      pend_count = '0;
      smear      = '0;
      errors     = 0;
    endfunction

    // one line per mismatch
    task report(input string what);
      $display("  mismatch: %s", what);
      errors++;
    endtask

    // register write as the block sees it
    function void write_reg(input logic [gpdp_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [gpdp_pkg::CFG_DATA_W-1:0] data);
      if (idx == gpdp_pkg::REG_OUT_MODE) out_mode = data[2:0];
      else if (idx == gpdp_pkg::REG_BOLD_ENABLE) bold_on = data[0];
    endfunction

    // work out the bytes one accepted pixel gives
    function void note_pixel(input logic [7:0] v, input logic re, input logic ge);
      glyph_byte_t outs[2];
      int          n;
      logic [3:0]  code;
      int          nbits;
      int          total;
      logic [11:0] shifted;
      logic [7:0]  b;
      logic [7:0]  c;
      logic        set;
      n = 0;
      outs[0] = '0;
      outs[1] = '0;
      if (out_mode == gpdp_pkg::MODE_TWO_BIT || out_mode == gpdp_pkg::MODE_FOUR_BIT ||
          out_mode == gpdp_pkg::MODE_ONE_BIT) begin
        // packed modes, row end plays no part
        if (out_mode == gpdp_pkg::MODE_TWO_BIT) begin
          nbits = 2;
          code = (v > 200) ? 4'd3 : (v > 150) ? 4'd2 : (v > 100) ? 4'd1 : 4'd0;
        end else if (out_mode == gpdp_pkg::MODE_FOUR_BIT) begin
          nbits = 4;
          code = 4'((int'(v) * 15) / 255);
        end else begin
          nbits = 1;
          code = (v != 0) ? 4'd1 : 4'd0;
        end
        total = int'(pend_count) + nbits;
        shifted = (12'(pend_bits) << nbits) | 12'(code);
        if (total >= 8) begin
          outs[n].value = 8'(shifted >> (total - 8));
          n++;
          pend_bits  = '0;
          pend_count = '0;
        end else begin
          pend_bits  = shifted[7:0];
          pend_count = 3'(total);
        end
        // flush of a partial byte, left-aligned
        if (ge && pend_count != 0) begin
          outs[n].value = 8'(pend_bits << (8 - int'(pend_count)));
          n++;
        end
      end else begin
        // byte-wide modes, unused codes behave as gray
        c = bold_on ? smear : 8'd0;
        if (out_mode == gpdp_pkg::MODE_MONO8) begin
          set = (v != 0);
          b = (set || c != 0) ? 8'd255 : 8'd0;
          c = set ? 8'd255 : 8'd0;
        end else if (v > 31) begin
          b = (c > v) ? c : v;
          c = v;
        end else begin
          b = v;
          c = '0;
        end
        if (!bold_on) c = '0;
        outs[n].value = b;
        n++;
        if (re || ge) begin
          if (bold_on) begin
            outs[n].value = c;
            n++;
          end
          c = '0;
        end
        smear = c;
      end
      if (n > 0) begin
        outs[n-1].run_last   = 1'b1;
        outs[n-1].glyph_last = ge;
      end
      for (int i = 0; i < n; i++) expected_bytes.push_back(outs[i]);
      if (ge) begin
        pend_bits  = '0;
        pend_count = '0;
        smear      = '0;
      end
    endfunction

    // compare one byte transfer with the oldest expectation
    task check_byte(input logic [7:0] b, input logic rl, input logic gl);
      glyph_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", b));
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.value)
          report($sformatf("out_byte %02h, expected %02h", b, e.value));
        if (rl !== e.run_last)
          report($sformatf("run_last %b, expected %b (byte %02h)", rl, e.run_last, b));
        if (gl !== e.glyph_last)
          report($sformatf("glyph_last %b, expected %b (byte %02h)", gl, e.glyph_last, b));
      end
    endtask

    // anything still waiting at the end never arrived
    task check_leftover();
      if (expected_bytes.size() != 0)
        report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
    endtask

  endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the glyph pixel depth packer. A short directed run covers the
// threshold edges, every output mode, bold smear and mid-byte mode changes;
// then random glyphs of random size run under random register settings,
// with random gaps on the pixel side and random stalls on the byte side.
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEM_TARGET = 925;
  localparam int CALM_ITEMS  = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 4;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [gpdp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gpdp_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             push;
  logic                             full;
  logic [7:0]                       pixel_value;
  logic                             row_end;
  logic                             glyph_end;
  logic                             empty;
  logic                             pop;
  logic [7:0]                       out_byte;
  logic                             run_last;
  logic                             glyph_last;

  gpdp_tb_pkg::packer_byte_tracker sb;
  int   items = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;

  // glyph shape for the random part
  int glyph_w = 4;
  int glyph_h = 3;
  int col = 0;
  int row_idx = 0;

  glyph_pixel_depth_packer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .pixel_value(pixel_value),
    .row_end    (row_end),
    .glyph_end  (glyph_end),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .glyph_last (glyph_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL glyph_pixel_depth_packer");
    $finish;
  end

  // byte transfers go to the tracker
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_byte(out_byte, run_last, glyph_last);
  end

  // receiver: random stall bursts, steady pop near the end
  initial begin
    int   len;
    logic level;
    pop = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (calm) begin
        pop = 1'b1;
        @(negedge clk);
      end else begin
        level = ($urandom_range(0, 2) != 0);
        len = $urandom_range(1, 10);
        pop = level;
        repeat (len) @(negedge clk);
      end
    end
  end

  // one pixel transfer, called and left at a falling edge
  task automatic send_pixel(input logic [7:0] v, input logic re, input logic ge);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    push = 1'b1;
    pixel_value = v;
    row_end = re;
    glyph_end = ge;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(v, re, ge);
    items++;
    @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [gpdp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [gpdp_pkg::CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    sb.write_reg(idx, data);
    cfg_write = 1'b0;
  endtask

  // hold the sender until every expected byte has come or the bound is reached, then let the block settle
  task automatic drain(input int bound);
    int n;
    n = 0;
    push = 1'b0;
    while (sb.expected_bytes.size() != 0 && n < bound) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // next pixel of a random glyph, with some malformed markers mixed in
  task automatic next_pixel(output logic [7:0] v, output logic re, output logic ge);
    int pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0: v = 8'd0;
      1: v = 8'd255;
      2: begin
        case ($urandom_range(0, 9))
          0: v = 8'd31;
          1: v = 8'd32;
          2: v = 8'd100;
          3: v = 8'd101;
          4: v = 8'd150;
          5: v = 8'd151;
          6: v = 8'd200;
          7: v = 8'd201;
          8: v = 8'd16;
          default: v = 8'd17;
        endcase
      end
      default: v = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      re = 1'($urandom_range(0, 1));
      ge = ($urandom_range(0, 5) == 0);
    end else begin
      re = (col == glyph_w - 1);
      ge = re && (row_idx == glyph_h - 1);
      col++;
      if (re) begin
        col = 0;
        row_idx++;
      end
    end
    // start a fresh glyph shape after each glyph end
    if (ge) begin
      col = 0;
      row_idx = 0;
      glyph_w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      glyph_h = $urandom_range(1, 6);
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] v;
    logic       re;
    logic       ge;
    int         phase;
    int         phase_len;
    rst = 1'b1;
    push = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_value = '0;
    row_end = 1'b0;
    glyph_end = 1'b0;
    sb = new();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // gray8 as after reset, glyph end without row end
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd32, 1'b0, 1'b1);
    drain(2000);

    // gray8 bold: smear above and at the floor
    write_reg(gpdp_pkg::REG_BOLD_ENABLE, 3'd1);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd31, 1'b0, 1'b0);
    send_pixel(8'd100, 1'b0, 1'b0);
    send_pixel(8'd32, 1'b1, 1'b0);
    send_pixel(8'd5, 1'b0, 1'b1);
    drain(2000);

    // mono8 bold
    write_reg(gpdp_pkg::REG_OUT_MODE, gpdp_pkg::MODE_MONO8);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd1, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b1, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b1);
    drain(2000);

    // two-bit thresholds, bold left on and row end ignored
    write_reg(gpdp_pkg::REG_OUT_MODE, gpdp_pkg::MODE_TWO_BIT);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd150, 1'b0, 1'b0);
    send_pixel(8'd100, 1'b1, 1'b0);
    send_pixel(8'd201, 1'b0, 1'b1);
    drain(2000);

    // seven one-bit codes, then a four-bit code that overflows the byte
    write_reg(gpdp_pkg::REG_OUT_MODE, gpdp_pkg::MODE_ONE_BIT);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd1, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd17, 1'b0, 1'b0);
    drain(2000);
    write_reg(gpdp_pkg::REG_OUT_MODE, gpdp_pkg::MODE_FOUR_BIT);
    send_pixel(8'd255, 1'b0, 1'b1);

    // random glyphs under changing settings
    phase = 0;
    while (items < ITEM_TARGET) begin
      drain(2000);
      if (phase == 0) write_reg(gpdp_pkg::REG_OUT_MODE, 3'd7);
      else if (phase == 1) write_reg(gpdp_pkg::REG_OUT_MODE, gpdp_pkg::MODE_TWO_BIT);
      else write_reg(gpdp_pkg::REG_OUT_MODE, 3'($urandom_range(0, 7)));
      write_reg(gpdp_pkg::REG_BOLD_ENABLE, 3'($urandom_range(0, 7)));
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        calm = (items >= ITEM_TARGET - CALM_ITEMS);
        next_pixel(v, re, ge);
        send_pixel(v, re, ge);
      end
      phase++;
    end

    drain(4000);
    sb.check_leftover();
    if (sb.errors == 0) $display("PASS glyph_pixel_depth_packer");
    else $display("FAIL glyph_pixel_depth_packer");
    $finish;
  end

endmodule
